// ===== hdl/cpv_pkg.sv =====
package cpv_pkg;

  // register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OVS_TOL      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCHED_INV_W  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT    = 3'd7;

  // reset values of the factor registers (1.0 in Q16.16)
  localparam logic [30:0] OVS_TOL_RESET     = 31'd65536;
  localparam logic [30:0] SCHED_INV_W_RESET = 31'd65536;

  // control modes and option bits of mode_flags
  localparam logic [1:0] MODE_TORQUE   = 2'd0;
  localparam int unsigned FLAG_SCHED   = 2;
  localparam int unsigned FLAG_VLIM    = 3;
  localparam int unsigned FLAG_OVS     = 4;
  localparam int unsigned FLAG_TQLIM   = 5;

  // status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_POS_INVAL = 2'd1;
  localparam logic [1:0] STATUS_VEL_INVAL = 2'd2;
  localparam logic [1:0] STATUS_OVERSPEED = 2'd3;

  // multiplier digit width, bits of the second operand per cycle
  localparam int unsigned MUL_DIGIT = 16;

  typedef struct packed {
    logic signed [31:0] position_setpoint;
    logic signed [31:0] position_estimate;
    logic               position_valid;
    logic signed [31:0] velocity_setpoint;
    logic signed [31:0] vel_est;
    logic               velocity_valid;
    logic signed [31:0] torque_feedforward;
    logic        [30:0] torque_ceiling;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] torque_command;
    logic        [1:0]  status;
    logic               torque_saturated;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  mode_flags;
    logic [30:0] position_gain;
    logic [30:0] velocity_gain;
    logic [30:0] integrator_gain_per_tick;
    logic [30:0] velocity_limit;
    logic [30:0] overspeed_tolerance;
    logic [30:0] sched_inverse_width;
    logic [30:0] integrator_limit;
  } cfg_t;

endpackage

// ===== hdl/cascaded_position_velocity_pi_core.sv =====
// Latency from input beat to output valid is shortest in torque mode with the overspeed check and
// velocity limit off, longest in position mode with all options on, and grows with the widths.
// The core takes a new item only once the previous one has reached the output register: the single
// shared multiplier, taking one 16-bit digit per cycle, is used up to 7 times.
// A new item is taken while the previous result still waits in the output register.
// Reset clears the sequencer, the integrator, the output valid and the registers to defaults.
module cascaded_position_velocity_pi_core #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  cpv_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output cpv_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cpv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned EW = ((DW > 32) ? DW : 32) + 2;
  localparam int unsigned OW = (DW > FRAC_BITS + 1) ? DW : FRAC_BITS + 2;

  localparam logic signed [EW-1:0] VMAX_W  = (EW'(1) <<< (DW-1)) - EW'(1);
  localparam logic signed [EW-1:0] VMIN_W  = ~VMAX_W;
  localparam logic signed [DW-1:0] VMAX_D  = VMAX_W[DW-1:0];
  localparam logic signed [DW-1:0] VMIN_D  = ~VMAX_D;
  localparam logic signed [EW-1:0] T32_MAX = (EW'(1) <<< 31) - EW'(1);
  localparam logic signed [EW-1:0] T32_MIN = ~T32_MAX;
  localparam longint DECAY_VAL = ((longint'(1) << FRAC_BITS) * 99) / 100;
  localparam logic signed [OW-1:0] ONE_O   = OW'(1) <<< FRAC_BITS;
  localparam logic signed [OW-1:0] DECAY_O = OW'(DECAY_VAL);

  // sequencer states
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_POS    = 5'd1;
  localparam logic [4:0] ST_PG     = 5'd2;
  localparam logic [4:0] ST_PG_W   = 5'd3;
  localparam logic [4:0] ST_SCH    = 5'd4;
  localparam logic [4:0] ST_SCH_W  = 5'd5;
  localparam logic [4:0] ST_VLIM   = 5'd6;
  localparam logic [4:0] ST_OVS    = 5'd7;
  localparam logic [4:0] ST_OVS_W  = 5'd8;
  localparam logic [4:0] ST_VEL    = 5'd9;
  localparam logic [4:0] ST_VG     = 5'd10;
  localparam logic [4:0] ST_VG_W   = 5'd11;
  localparam logic [4:0] ST_VE     = 5'd12;
  localparam logic [4:0] ST_VE_W   = 5'd13;
  localparam logic [4:0] ST_VI     = 5'd14;
  localparam logic [4:0] ST_TMAX   = 5'd15;
  localparam logic [4:0] ST_TMAX_W = 5'd16;
  localparam logic [4:0] ST_TMIN   = 5'd17;
  localparam logic [4:0] ST_TMIN_W = 5'd18;
  localparam logic [4:0] ST_LIM    = 5'd19;
  localparam logic [4:0] ST_INT    = 5'd20;
  localparam logic [4:0] ST_DEC_W  = 5'd21;
  localparam logic [4:0] ST_IG_W   = 5'd22;
  localparam logic [4:0] ST_IE     = 5'd23;
  localparam logic [4:0] ST_IE_W   = 5'd24;
  localparam logic [4:0] ST_ICLAMP = 5'd25;
  localparam logic [4:0] ST_DONE   = 5'd26;
  localparam logic [4:0] ST_FAULT  = 5'd27;

  function automatic logic signed [EW-1:0] ext_w(input logic signed [DW-1:0] x);
    return EW'(x);
  endfunction

  function automatic logic signed [DW-1:0] sat_w(input logic signed [EW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > VMAX_W) begin
      r = VMAX_D;
    end else if (v < VMIN_W) begin
      r = VMIN_D;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DW-1:0] sat_in(input logic signed [31:0] x);
    return sat_w(EW'(x));
  endfunction

  function automatic logic signed [DW-1:0] ucfg(input logic [30:0] x);
    logic signed [EW-1:0] w;
    w = EW'(x);
    return sat_w(w);
  endfunction

  function automatic logic signed [DW-1:0] add_sat(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
    return sat_w(ext_w(a) + ext_w(b));
  endfunction

  function automatic logic signed [DW-1:0] sub_sat(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
    return sat_w(ext_w(a) - ext_w(b));
  endfunction

  function automatic logic signed [DW-1:0] clampv(input logic signed [DW-1:0] v,
                                                 input logic signed [DW-1:0] lo,
                                                 input logic signed [DW-1:0] hi);
    logic signed [DW-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  cpv_pkg::cfg_t cfg;

  logic [4:0]           state_q, state_d;
  logic signed [DW-1:0] ps_q, ps_d, pe_q, pe_d, vd_q, vd_d, ve_q, ve_d;
  logic signed [DW-1:0] tq_q, tq_d, tl_q, tl_d, perr_q, perr_d;
  logic signed [DW-1:0] verr_q, verr_d, tmp_q, tmp_d, integ_q, integ_d;
  logic signed [OW-1:0] mult_q, mult_d;
  logic                 pvalid_q, pvalid_d, vvalid_q, vvalid_d;
  logic                 limited_q, limited_d;
  logic [1:0]           stat_q, stat_d;
  logic                 out_valid_q, out_valid_d;
  cpv_pkg::out_item_t   out_q, out_d;

  logic                 mul_start;
  logic signed [OW-1:0] mul_a, mul_b;
  logic                 mul_done;
  logic signed [DW-1:0] mul_res;

  logic signed [DW-1:0] pg_c, vg_c, ig_c, vl_c, tol_c, siw_c, il_c;
  logic signed [DW-1:0] perr_abs;
  logic signed [EW-1:0] ve_mag;
  logic signed [EW-1:0] tq_ext;
  logic signed [31:0]   tq_out;
  logic                 pos_mode, vel_mode;
  logic                 out_free;

  cpv_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  cpv_mul #(
    .DATA_WIDTH (DW),
    .OPER_WIDTH (OW),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // register values clipped to the data range
  assign pg_c  = ucfg(cfg.position_gain);
  assign vg_c  = ucfg(cfg.velocity_gain);
  assign ig_c  = ucfg(cfg.integrator_gain_per_tick);
  assign vl_c  = ucfg(cfg.velocity_limit);
  assign tol_c = ucfg(cfg.overspeed_tolerance);
  assign siw_c = ucfg(cfg.sched_inverse_width);
  assign il_c  = ucfg(cfg.integrator_limit);

  assign pos_mode = cfg.mode_flags[1];
  assign vel_mode = cfg.mode_flags[1:0] != cpv_pkg::MODE_TORQUE;

  assign perr_abs = sat_w(perr_q[DW-1] ? -ext_w(perr_q) : ext_w(perr_q));
  assign ve_mag   = ve_q[DW-1] ? -ext_w(ve_q) : ext_w(ve_q);

  // final torque fitted to the 32-bit port
  assign tq_ext = ext_w(tq_q);
  always_comb begin
    if (tq_ext > T32_MAX) begin
      tq_out = T32_MAX[31:0];
    end else if (tq_ext < T32_MIN) begin
      tq_out = T32_MIN[31:0];
    end else begin
      tq_out = tq_ext[31:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer and datapath
  always_comb begin
    state_d     = state_q;
    ps_d        = ps_q;
    pe_d        = pe_q;
    pvalid_d    = pvalid_q;
    vd_d        = vd_q;
    ve_d        = ve_q;
    vvalid_d    = vvalid_q;
    tq_d        = tq_q;
    tl_d        = tl_q;
    perr_d      = perr_q;
    mult_d      = mult_q;
    verr_d      = verr_q;
    tmp_d       = tmp_q;
    limited_d   = limited_q;
    stat_d      = stat_q;
    integ_d     = integ_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_start   = 1'b0;
    mul_a       = OW'(pg_c);
    mul_b       = OW'(perr_q);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ps_d      = sat_in(in_data_i.position_setpoint);
          pe_d      = sat_in(in_data_i.position_estimate);
          pvalid_d  = in_data_i.position_valid;
          vd_d      = sat_in(in_data_i.velocity_setpoint);
          ve_d      = sat_in(in_data_i.vel_est);
          vvalid_d  = in_data_i.velocity_valid;
          tq_d      = sat_in(in_data_i.torque_feedforward);
          tl_d      = ucfg(in_data_i.torque_ceiling);
          mult_d    = ONE_O;
          verr_d    = '0;
          limited_d = 1'b0;
          state_d   = ST_POS;
        end
      end
      // position loop
      ST_POS: begin
        if (pos_mode) begin
          if (!pvalid_q) begin
            stat_d  = cpv_pkg::STATUS_POS_INVAL;
            state_d = ST_FAULT;
          end else begin
            perr_d  = sub_sat(ps_q, pe_q);
            state_d = ST_PG;
          end
        end else begin
          state_d = ST_VLIM;
        end
      end
      ST_PG: begin
        mul_start = 1'b1;
        mul_a     = OW'(pg_c);
        mul_b     = OW'(perr_q);
        state_d   = ST_PG_W;
      end
      ST_PG_W: begin
        if (mul_done) begin
          vd_d    = add_sat(vd_q, mul_res);
          state_d = cfg.mode_flags[cpv_pkg::FLAG_SCHED] ? ST_SCH : ST_VLIM;
        end
      end
      // gain schedule from the position error
      ST_SCH: begin
        mul_start = 1'b1;
        mul_a     = OW'(perr_abs);
        mul_b     = OW'(siw_c);
        state_d   = ST_SCH_W;
      end
      ST_SCH_W: begin
        if (mul_done) begin
          if (OW'(mul_res) <= ONE_O) begin
            mult_d = OW'(mul_res);
          end
          state_d = ST_VLIM;
        end
      end
      ST_VLIM: begin
        if (cfg.mode_flags[cpv_pkg::FLAG_VLIM]) begin
          vd_d = clampv(vd_q, -vl_c, vl_c);
        end
        state_d = ST_OVS;
      end
      // overspeed check
      ST_OVS: begin
        if (cfg.mode_flags[cpv_pkg::FLAG_OVS]) begin
          if (!vvalid_q) begin
            stat_d  = cpv_pkg::STATUS_VEL_INVAL;
            state_d = ST_FAULT;
          end else begin
            mul_start = 1'b1;
            mul_a     = OW'(tol_c);
            mul_b     = OW'(vl_c);
            state_d   = ST_OVS_W;
          end
        end else begin
          state_d = ST_VEL;
        end
      end
      ST_OVS_W: begin
        if (mul_done) begin
          if (ve_mag > ext_w(mul_res)) begin
            stat_d  = cpv_pkg::STATUS_OVERSPEED;
            state_d = ST_FAULT;
          end else begin
            state_d = ST_VEL;
          end
        end
      end
      // velocity loop or torque-mode velocity limit
      ST_VEL: begin
        if (vel_mode || cfg.mode_flags[cpv_pkg::FLAG_TQLIM]) begin
          if (!vvalid_q) begin
            stat_d  = cpv_pkg::STATUS_VEL_INVAL;
            state_d = ST_FAULT;
          end else if (vel_mode) begin
            verr_d  = sub_sat(vd_q, ve_q);
            state_d = ST_VG;
          end else begin
            state_d = ST_TMAX;
          end
        end else begin
          state_d = ST_LIM;
        end
      end
      ST_VG: begin
        mul_start = 1'b1;
        mul_a     = OW'(vg_c);
        mul_b     = mult_q;
        state_d   = ST_VG_W;
      end
      ST_VG_W: begin
        if (mul_done) begin
          tmp_d   = mul_res;
          state_d = ST_VE;
        end
      end
      ST_VE: begin
        mul_start = 1'b1;
        mul_a     = OW'(tmp_q);
        mul_b     = OW'(verr_q);
        state_d   = ST_VE_W;
      end
      ST_VE_W: begin
        if (mul_done) begin
          tq_d    = add_sat(tq_q, mul_res);
          state_d = ST_VI;
        end
      end
      ST_VI: begin
        tq_d    = add_sat(tq_q, integ_q);
        state_d = ST_LIM;
      end
      ST_TMAX: begin
        mul_start = 1'b1;
        mul_a     = OW'(vg_c);
        mul_b     = OW'(sub_sat(vl_c, ve_q));
        state_d   = ST_TMAX_W;
      end
      ST_TMAX_W: begin
        if (mul_done) begin
          tmp_d   = mul_res;
          state_d = ST_TMIN;
        end
      end
      ST_TMIN: begin
        mul_start = 1'b1;
        mul_a     = OW'(vg_c);
        mul_b     = OW'(sat_w(-ext_w(vl_c) - ext_w(ve_q)));
        state_d   = ST_TMIN_W;
      end
      ST_TMIN_W: begin
        if (mul_done) begin
          tq_d    = clampv(tq_q, mul_res, tmp_q);
          state_d = ST_LIM;
        end
      end
      // torque ceiling
      ST_LIM: begin
        if (tq_q > tl_q) begin
          limited_d = 1'b1;
          tq_d      = tl_q;
        end else if (tq_q < -tl_q) begin
          limited_d = 1'b1;
          tq_d      = -tl_q;
        end
        state_d = ST_INT;
      end
      // integrator: cleared in torque mode, else decays while limited or accumulates, then is clamped
      ST_INT: begin
        if (!vel_mode) begin
          integ_d = '0;
          state_d = ST_DONE;
        end else if (limited_q) begin
          mul_start = 1'b1;
          mul_a     = OW'(integ_q);
          mul_b     = DECAY_O;
          state_d   = ST_DEC_W;
        end else begin
          mul_start = 1'b1;
          mul_a     = OW'(ig_c);
          mul_b     = mult_q;
          state_d   = ST_IG_W;
        end
      end
      ST_DEC_W: begin
        if (mul_done) begin
          integ_d = mul_res;
          state_d = ST_ICLAMP;
        end
      end
      ST_IG_W: begin
        if (mul_done) begin
          tmp_d   = mul_res;
          state_d = ST_IE;
        end
      end
      ST_IE: begin
        mul_start = 1'b1;
        mul_a     = OW'(tmp_q);
        mul_b     = OW'(verr_q);
        state_d   = ST_IE_W;
      end
      ST_IE_W: begin
        if (mul_done) begin
          integ_d = add_sat(integ_q, mul_res);
          state_d = ST_ICLAMP;
        end
      end
      ST_ICLAMP: begin
        integ_d = clampv(integ_q, -il_c, il_c);
        state_d = ST_DONE;
      end
      // result beat into the output register
      ST_DONE: begin
        if (out_free) begin
          out_d.torque_command   = tq_out;
          out_d.status           = cpv_pkg::STATUS_OK;
          out_d.torque_saturated = limited_q;
          out_valid_d            = 1'b1;
          state_d                = ST_IDLE;
        end
      end
      ST_FAULT: begin
        if (out_free) begin
          out_d.torque_command   = '0;
          out_d.status           = stat_q;
          out_d.torque_saturated = 1'b0;
          out_valid_d            = 1'b1;
          state_d                = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      integ_q     <= integ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ps_q      <= ps_d;
    pe_q      <= pe_d;
    pvalid_q  <= pvalid_d;
    vd_q      <= vd_d;
    ve_q      <= ve_d;
    vvalid_q  <= vvalid_d;
    tq_q      <= tq_d;
    tl_q      <= tl_d;
    perr_q    <= perr_d;
    mult_q    <= mult_d;
    verr_q    <= verr_d;
    tmp_q     <= tmp_d;
    limited_q <= limited_d;
    stat_q    <= stat_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign cfg_ready_o = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // fault beats carry no torque
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != cpv_pkg::STATUS_OK
      |-> out_data_o.torque_command == '0 && !out_data_o.torque_saturated)
    else $error("fault beat with nonzero torque");

  // multiplier results arrive only while the sequencer waits for them
  a_mul_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == ST_PG_W || state_q == ST_SCH_W || state_q == ST_OVS_W ||
                 state_q == ST_VG_W || state_q == ST_VE_W || state_q == ST_TMAX_W ||
                 state_q == ST_TMIN_W || state_q == ST_DEC_W || state_q == ST_IG_W ||
                 state_q == ST_IE_W)
    else $error("multiplier result outside a wait state");

  // integrator stays inside its clamp once an item completes
  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> integ_q <= il_c && integ_q >= -il_c)
    else $error("integrator outside its limit");

  // no new item while the multiplier is being started
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |=> in_stall_o)
    else $error("input taken during a multiply");

endmodule

// ===== hdl/cpv_regs.sv =====
module cpv_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [cpv_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [31:0]                    wr_data_i,
  output cpv_pkg::cfg_t                  cfg_o
);

  cpv_pkg::cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        cpv_pkg::REG_MODE_FLAGS:  cfg_d.mode_flags               = wr_data_i[5:0];
        cpv_pkg::REG_POS_GAIN:    cfg_d.position_gain            = wr_data_i[30:0];
        cpv_pkg::REG_VEL_GAIN:    cfg_d.velocity_gain            = wr_data_i[30:0];
        cpv_pkg::REG_INT_GAIN:    cfg_d.integrator_gain_per_tick = wr_data_i[30:0];
        cpv_pkg::REG_VEL_LIMIT:   cfg_d.velocity_limit           = wr_data_i[30:0];
        cpv_pkg::REG_OVS_TOL:     cfg_d.overspeed_tolerance      = wr_data_i[30:0];
        cpv_pkg::REG_SCHED_INV_W: cfg_d.sched_inverse_width      = wr_data_i[30:0];
        cpv_pkg::REG_INT_LIMIT:   cfg_d.integrator_limit         = wr_data_i[30:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_flags               <= '0;
      cfg_q.position_gain            <= '0;
      cfg_q.velocity_gain            <= '0;
      cfg_q.integrator_gain_per_tick <= '0;
      cfg_q.velocity_limit           <= '0;
      cfg_q.overspeed_tolerance      <= cpv_pkg::OVS_TOL_RESET;
      cfg_q.sched_inverse_width      <= cpv_pkg::SCHED_INV_W_RESET;
      cfg_q.integrator_limit         <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/cpv_mul.sv =====
module cpv_mul #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned OPER_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [OPER_WIDTH-1:0] a_i,
  input  logic signed [OPER_WIDTH-1:0] b_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] res_o
);

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned OW   = OPER_WIDTH;
  localparam int unsigned CW   = cpv_pkg::MUL_DIGIT;
  localparam int unsigned NCH  = (OW + CW - 1) / CW;
  localparam int unsigned BW   = NCH * CW;
  localparam int unsigned PW   = OW + BW;
  localparam int unsigned CNTW = $clog2(NCH + 1);

  logic [OW-1:0]          ua_q, ua_d;
  logic [BW-1:0]          ub_q, ub_d;
  logic                   neg_q, neg_d;
  logic [PW-1:0]          acc_q, acc_d;
  logic [CNTW-1:0]        cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic signed [DW-1:0]   res_q, res_d;

  logic [CW-1:0]          digit;
  logic [OW+CW-1:0]       pp;
  logic [PW-1:0]          quo;
  logic [PW-1:0]          lim;
  logic [PW-1:0]          mag;
  logic [DW-1:0]          mag_dw;
  logic [OW-1:0]          abs_a;
  logic [OW-1:0]          abs_b;

  // one digit of the multiplier per cycle, most significant first
  assign digit  = ub_q[BW-1 -: CW];
  assign pp     = (OW+CW)'(ua_q) * (OW+CW)'(digit);

  // drop fraction bits (toward zero on the magnitude), then saturate
  assign quo    = acc_q >> FRAC_BITS;
  assign lim    = neg_q ? (PW'(1) << (DW-1)) : ((PW'(1) << (DW-1)) - PW'(1));
  assign mag    = (quo > lim) ? lim : quo;
  assign mag_dw = mag[DW-1:0];

  assign abs_a  = a_i[OW-1] ? OW'(-a_i) : OW'(a_i);
  assign abs_b  = b_i[OW-1] ? OW'(-b_i) : OW'(b_i);

  // operand load, digit steps and final rounding
  always_comb begin
    ua_d   = ua_q;
    ub_d   = ub_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    res_d  = res_q;
    done_d = 1'b0;
    if (start_i) begin
      ua_d   = abs_a;
      ub_d   = BW'(abs_b);
      neg_d  = a_i[OW-1] ^ b_i[OW-1];
      acc_d  = '0;
      cnt_d  = CNTW'(NCH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        acc_d = (acc_q << CW) + PW'(pp);
        ub_d  = ub_q << CW;
        cnt_d = cnt_q - CNTW'(1);
      end else begin
        res_d  = neg_q ? -$signed(mag_dw) : $signed(mag_dw);
        done_d = 1'b1;
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ua_q  <= ua_d;
    ub_q  <= ub_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam longint QMAX  = 64'sd2147483647;
  localparam longint QMIN  = -64'sd2147483648;
  localparam longint QONE  = 64'sd65536;
  localparam longint DECAY = 64'sd64880;  // floor(0.99 * 2^16)

  localparam logic [1:0] MODE_VELOCITY = 2'd1;
  localparam logic [1:0] MODE_POSITION = 2'd2;
  localparam logic [1:0] MODE_POS_ALT  = 2'd3;

  localparam int NUM_PHASES      = 8;
  localparam int TICKS_PER_PHASE = 180;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 60;

  typedef enum int {SET_TYPICAL, SET_MAX, SET_ZERO} reg_set_e;

  // expected torque commands and the controller state behind them
  class torque_scoreboard;
    cpv_pkg::cfg_t      regs;
    longint             integ_torque;
    cpv_pkg::out_item_t expected_cmds[$];
    int unsigned        errors;

    function new();
      regs = '0;
      regs.overspeed_tolerance = cpv_pkg::OVS_TOL_RESET;
      regs.sched_inverse_width = cpv_pkg::SCHED_INV_W_RESET;
      integ_torque = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [cpv_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        cpv_pkg::REG_MODE_FLAGS:  regs.mode_flags = value[5:0];
        cpv_pkg::REG_POS_GAIN:    regs.position_gain = value[30:0];
        cpv_pkg::REG_VEL_GAIN:    regs.velocity_gain = value[30:0];
        cpv_pkg::REG_INT_GAIN:    regs.integrator_gain_per_tick = value[30:0];
        cpv_pkg::REG_VEL_LIMIT:   regs.velocity_limit = value[30:0];
        cpv_pkg::REG_OVS_TOL:     regs.overspeed_tolerance = value[30:0];
        cpv_pkg::REG_SCHED_INV_W: regs.sched_inverse_width = value[30:0];
        cpv_pkg::REG_INT_LIMIT:   regs.integrator_limit = value[30:0];
        default: ;
      endcase
    endfunction

    static function longint sat(longint v);
      return (v > QMAX) ? QMAX : ((v < QMIN) ? QMIN : v);
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // fixed point product, truncated toward zero, saturated
    static function longint qmul(longint a, longint b);
      logic        neg;
      logic [63:0] ua, ub, q, lim;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      q = (ua * ub) >> 16;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      if (q > lim) q = lim;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function cpv_pkg::out_item_t control_law(cpv_pkg::in_item_t it);
      cpv_pkg::out_item_t r;
      logic [1:0] mode;
      logic       sched_en, vlim_en, ovs_en, tqlim_en, limited;
      longint     ps, pe, vdes, ve, tq, tlim, vl, vg, mult, verr, perr, m, mag;
      longint     tmax, tmin, il;
      mode = regs.mode_flags[1:0];
      sched_en = regs.mode_flags[cpv_pkg::FLAG_SCHED];
      vlim_en = regs.mode_flags[cpv_pkg::FLAG_VLIM];
      ovs_en = regs.mode_flags[cpv_pkg::FLAG_OVS];
      tqlim_en = regs.mode_flags[cpv_pkg::FLAG_TQLIM];
      ps = longint'($signed(it.position_setpoint));
      pe = longint'($signed(it.position_estimate));
      vdes = longint'($signed(it.velocity_setpoint));
      ve = longint'($signed(it.vel_est));
      tq = longint'($signed(it.torque_feedforward));
      tlim = longint'(it.torque_ceiling);
      vl = longint'(regs.velocity_limit);
      vg = longint'(regs.velocity_gain);
      mult = QONE;
      verr = 0;
      limited = 1'b0;
      r = '0;
      // position loop and gain scheduling
      if (mode >= MODE_POSITION) begin
        if (!it.position_valid) begin
          r.status = cpv_pkg::STATUS_POS_INVAL;
          return r;
        end
        perr = sat(ps - pe);
        vdes = sat(vdes + qmul(longint'(regs.position_gain), perr));
        m = qmul(sat((perr < 0) ? -perr : perr), longint'(regs.sched_inverse_width));
        if (sched_en && m <= QONE) mult = m;
      end
      if (vlim_en) vdes = clip(vdes, -vl, vl);
      // overspeed check
      if (ovs_en) begin
        mag = (ve < 0) ? -ve : ve;
        if (!it.velocity_valid) begin
          r.status = cpv_pkg::STATUS_VEL_INVAL;
          return r;
        end
        if (mag > qmul(longint'(regs.overspeed_tolerance), vl)) begin
          r.status = cpv_pkg::STATUS_OVERSPEED;
          return r;
        end
      end
      // velocity pi loop or torque mode velocity limit
      if (mode != cpv_pkg::MODE_TORQUE) begin
        if (!it.velocity_valid) begin
          r.status = cpv_pkg::STATUS_VEL_INVAL;
          return r;
        end
        verr = sat(vdes - ve);
        tq = sat(tq + qmul(qmul(vg, mult), verr));
        tq = sat(tq + integ_torque);
      end else if (tqlim_en) begin
        if (!it.velocity_valid) begin
          r.status = cpv_pkg::STATUS_VEL_INVAL;
          return r;
        end
        tmax = qmul(vg, sat(vl - ve));
        tmin = qmul(vg, sat(-vl - ve));
        tq = clip(tq, tmin, tmax);
      end
      // ceiling clamp
      if (tq > tlim) begin
        limited = 1'b1;
        tq = tlim;
      end else if (tq < -tlim) begin
        limited = 1'b1;
        tq = -tlim;
      end
      // integrator: cleared in torque mode, decays while limited, otherwise accumulates, then clipped
      if (mode == cpv_pkg::MODE_TORQUE) begin
        integ_torque = 0;
      end else begin
        il = longint'(regs.integrator_limit);
        if (limited)
          integ_torque = qmul(integ_torque, DECAY);
        else
          integ_torque = sat(integ_torque + qmul(qmul(longint'(regs.integrator_gain_per_tick),
                                                      mult), verr));
        integ_torque = clip(integ_torque, -il, il);
      end
      r.torque_command = tq[31:0];
      r.status = cpv_pkg::STATUS_OK;
      r.torque_saturated = limited;
      return r;
    endfunction

    function void note_tick(cpv_pkg::in_item_t it);
      expected_cmds.push_back(control_law(it));
    endfunction

    function void check_command(cpv_pkg::out_item_t got);
      cpv_pkg::out_item_t want;
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected beat torque=%0d status=%0d sat=%0b", $time,
                 got.torque_command, got.status, got.torque_saturated);
        errors++;
        return;
      end
      want = expected_cmds.pop_front();
      if (got.torque_command !== want.torque_command) begin
        $display("%0t: torque_command expected %0d, got %0d", $time,
                 want.torque_command, got.torque_command);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.torque_saturated !== want.torque_saturated) begin
        $display("%0t: torque_saturated expected %0b, got %0b", $time,
                 want.torque_saturated, got.torque_saturated);
        errors++;
      end
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  cpv_pkg::in_item_t             in_data_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  cpv_pkg::out_item_t            out_data_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [cpv_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]                   cfg_data_i;

  torque_scoreboard sb;
  int               idle_pct;
  bit               hold_now;

  cascaded_position_velocity_pi_core dut (.*);

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // watch both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_tick(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_command(out_data_o);
  end

  // receiver: random stall bursts plus one long hold-off
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_now) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_now = 1'b0;
        out_stall_i <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic int near(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [31:0] extreme_q();
    case ($urandom_range(0, 4))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic cpv_pkg::in_item_t rand_tick();
    cpv_pkg::in_item_t it;
    int unsigned       pick;
    pick = $urandom_range(0, 9);
    it.position_valid = ($urandom_range(0, 15) != 0);
    it.velocity_valid = ($urandom_range(0, 15) != 0);
    if (pick == 0) begin
      it.position_setpoint = $urandom();
      it.position_estimate = $urandom();
      it.velocity_setpoint = $urandom();
      it.vel_est = $urandom();
      it.torque_feedforward = $urandom();
      it.torque_ceiling = 31'($urandom());
    end else if (pick == 1) begin
      it.position_setpoint = extreme_q();
      it.position_estimate = extreme_q();
      it.velocity_setpoint = extreme_q();
      it.vel_est = extreme_q();
      it.torque_feedforward = extreme_q();
      it.torque_ceiling = ($urandom_range(0, 1) != 0) ? '1 : 31'($urandom_range(0, 1));
    end else begin
      // plausible operating point near the setpoint
      it.position_setpoint = near(1 << 21);
      it.position_estimate = it.position_setpoint + near(1 << 19);
      it.velocity_setpoint = near(1 << 20);
      it.vel_est = near(1 << 21);
      it.torque_feedforward = near(1 << 20);
      it.torque_ceiling = ($urandom_range(0, 7) == 0) ? 31'd0 :
                          31'($urandom_range(0, 1 << 22));
    end
    return it;
  endfunction

  // full scale ticks and ticks with invalid estimates
  function automatic cpv_pkg::in_item_t corner_tick(int k);
    cpv_pkg::in_item_t it;
    it = '0;
    case (k)
      0: begin
        it.position_setpoint = 32'sh7FFF_FFFF;
        it.position_estimate = 32'sh8000_0000;
        it.velocity_setpoint = 32'sh7FFF_FFFF;
        it.vel_est = 32'sh8000_0000;
        it.torque_feedforward = 32'sh7FFF_FFFF;
        it.torque_ceiling = '1;
        it.position_valid = 1'b1;
        it.velocity_valid = 1'b1;
      end
      1: begin
        it.position_setpoint = 32'sh8000_0000;
        it.position_estimate = 32'sh7FFF_FFFF;
        it.velocity_setpoint = 32'sh8000_0000;
        it.vel_est = 32'sh7FFF_FFFF;
        it.torque_feedforward = 32'sh8000_0000;
        it.position_valid = 1'b1;
        it.velocity_valid = 1'b1;
      end
      default: begin
        it.torque_feedforward = -32'sd65536;
        it.torque_ceiling = '1;
      end
    endcase
    return it;
  endfunction

  function automatic logic [30:0] reg_value(logic [cpv_pkg::CFG_IDX_W-1:0] idx,
                                            reg_set_e kind);
    if (kind == SET_ZERO) return '0;
    if (kind == SET_MAX) return '1;
    if ($urandom_range(0, 7) == 0) return 31'($urandom());
    case (idx)
      cpv_pkg::REG_POS_GAIN, cpv_pkg::REG_VEL_GAIN: return 31'($urandom_range(0, 1 << 18));
      cpv_pkg::REG_INT_GAIN:    return 31'($urandom_range(0, 1 << 13));
      cpv_pkg::REG_VEL_LIMIT:   return 31'($urandom_range(1 << 16, 1 << 21));
      cpv_pkg::REG_OVS_TOL:     return 31'($urandom_range(1 << 16, 3 << 15));
      cpv_pkg::REG_SCHED_INV_W: return 31'($urandom_range(1 << 10, 1 << 17));
      default:                  return 31'($urandom_range(0, 1 << 23));
    endcase
  endfunction

  function automatic logic [5:0] mode_word(logic [1:0] mode, logic sched, logic vlim,
                                           logic ovs, logic tqlim);
    logic [5:0] w;
    w = {4'b0, mode};
    w[cpv_pkg::FLAG_SCHED] = sched;
    w[cpv_pkg::FLAG_VLIM] = vlim;
    w[cpv_pkg::FLAG_OVS] = ovs;
    w[cpv_pkg::FLAG_TQLIM] = tqlim;
    return w;
  endfunction

  // one config beat; valid stays high for back to back writes
  task automatic write_reg(logic [cpv_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic configure(int ph);
    logic [5:0] flags;
    reg_set_e   kind;
    kind = SET_TYPICAL;
    case (ph)
      1: flags = mode_word(cpv_pkg::MODE_TORQUE, 1'b0, 1'b0, 1'b1, 1'b1);
      2: flags = mode_word(MODE_VELOCITY, 1'b0, 1'b1, 1'b1, 1'b0);
      3: flags = mode_word(MODE_POSITION, 1'b1, 1'b1, 1'b1, 1'b0);
      4: begin
        flags = mode_word(MODE_POS_ALT, 1'b1, 1'b1, 1'b1, 1'b1);
        kind = SET_MAX;
      end
      5: begin
        flags = mode_word(MODE_POSITION, 1'b1, 1'b0, 1'b0, 1'b0);
        kind = SET_ZERO;
      end
      6: flags = mode_word(MODE_VELOCITY, 1'b0, 1'b0, 1'b0, 1'b0);
      default: flags = 6'($urandom());
    endcase
    // unused upper data bits are random and must be ignored
    write_reg(cpv_pkg::REG_MODE_FLAGS, {26'($urandom()), flags});
    write_reg(cpv_pkg::REG_POS_GAIN,
              {1'($urandom()), reg_value(cpv_pkg::REG_POS_GAIN, kind)});
    write_reg(cpv_pkg::REG_VEL_GAIN,
              {1'($urandom()), reg_value(cpv_pkg::REG_VEL_GAIN, kind)});
    write_reg(cpv_pkg::REG_INT_GAIN,
              {1'($urandom()), reg_value(cpv_pkg::REG_INT_GAIN, kind)});
    write_reg(cpv_pkg::REG_VEL_LIMIT,
              {1'($urandom()), reg_value(cpv_pkg::REG_VEL_LIMIT, kind)});
    write_reg(cpv_pkg::REG_OVS_TOL,
              {1'($urandom()), reg_value(cpv_pkg::REG_OVS_TOL, kind)});
    write_reg(cpv_pkg::REG_SCHED_INV_W,
              {1'($urandom()), reg_value(cpv_pkg::REG_SCHED_INV_W, kind)});
    write_reg(cpv_pkg::REG_INT_LIMIT,
              {1'($urandom()), reg_value(cpv_pkg::REG_INT_LIMIT, kind)});
    cfg_valid_i <= 1'b0;
  endtask

  // offer one tick, optionally after an idle burst; returns at a falling edge
  task automatic send_tick(cpv_pkg::in_item_t it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_data_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    idle_pct = 0;
    hold_now = 1'b0;
    sb = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // phase 0 runs on the reset values
      if (ph != 0) configure(ph);
      idle_pct = (ph == NUM_PHASES - 1 || ph % 3 == 2) ? 0 : 25;
      for (int k = 0; k < 3; k++) send_tick(corner_tick(k));
      // long receiver hold-off while ticks keep coming
      if (ph == 1) hold_now = 1'b1;
      repeat (TICKS_PER_PHASE) send_tick(rand_tick());
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
